FILE: design/cvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cvr_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  // result queue: room for two pushes while the head waits
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } result_t;

  // up to two results per vertex, entry 0 goes out first
  typedef struct packed {
    logic [1:0]    num;
    result_t [1:0] ent;
  } push_t;

  typedef enum logic [1:0] {
    SEEN_NONE,
    SEEN_ONE,
    SEEN_TWO,
    SEEN_MANY
  } seen_e;

endpackage

`default_nettype wire

FILE: design/cvr_vertex_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cvr_vertex_if import cvr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   is_last;

  modport source (output valid, output point_x, output point_y, output is_last,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input is_last,
                  output ready);
endinterface

`default_nettype wire

FILE: design/cvr_kept_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cvr_kept_if import cvr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  logic   out_last;

  modport source (output valid, output out_x, output out_y, output out_last,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_last,
                  output ready);
endinterface

`default_nettype wire

FILE: design/cvr_cross_zero.sv
`timescale 1ns / 1ps
`default_nettype none

// (kept - held) x (next - held) == 0, exact at full product width
module cvr_cross_zero import cvr_pkg::*; (
  input  point_t kept_i,
  input  point_t held_i,
  input  point_t next_i,
  output logic   zero_o
);

  diff_t vpx, vpy, vnx, vny;
  prod_t prod_a, prod_b;

  assign vpx = diff_t'(kept_i.x) - diff_t'(held_i.x);
  assign vpy = diff_t'(kept_i.y) - diff_t'(held_i.y);
  assign vnx = diff_t'(next_i.x) - diff_t'(held_i.x);
  assign vny = diff_t'(next_i.y) - diff_t'(held_i.y);

  assign prod_a = prod_t'(vnx) * prod_t'(vpy);
  assign prod_b = prod_t'(vny) * prod_t'(vpx);

  assign zero_o = (prod_a == prod_b);

endmodule

`default_nettype wire

FILE: design/cvr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cvr_ctrl import cvr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   vld_i,
  input  point_t pt_i,
  input  logic   last_i,
  input  logic   room_i,
  output logic   fire_o,
  output push_t  push_o
);

  seen_e  seen_q, seen_d;
  point_t kept_q, kept_d;
  point_t held_q, held_d;
  logic   zero;
  logic   general;

  cvr_cross_zero u_cross (
    .kept_i (kept_q),
    .held_i (held_q),
    .next_i (pt_i),
    .zero_o (zero)
  );

  assign fire_o = vld_i & room_i;

  always_comb begin
    seen_d  = seen_q;
    kept_d  = kept_q;
    held_d  = held_q;
    push_o  = '0;
    general = 1'b0;

    if (fire_o) begin
      unique case (seen_q)
        SEEN_NONE: begin
          push_o.num    = 2'd1;
          push_o.ent[0] = '{x: pt_i.x, y: pt_i.y, last: last_i};
          if (!last_i) begin
            kept_d = pt_i;
            seen_d = SEEN_ONE;
          end
        end
        SEEN_ONE: begin
          if (last_i) begin
            push_o.num    = 2'd1;
            push_o.ent[0] = '{x: pt_i.x, y: pt_i.y, last: 1'b1};
            seen_d        = SEEN_NONE;
          end else begin
            held_d = pt_i;
            seen_d = SEEN_TWO;
          end
        end
        SEEN_TWO: begin
          // three-vertex line: everything goes out untested
          if (last_i) begin
            push_o.num    = 2'd2;
            push_o.ent[0] = '{x: held_q.x, y: held_q.y, last: 1'b0};
            push_o.ent[1] = '{x: pt_i.x, y: pt_i.y, last: 1'b1};
            seen_d        = SEEN_NONE;
          end else begin
            general = 1'b1;
          end
        end
        SEEN_MANY: general = 1'b1;
      endcase

      if (general) begin
        if (!zero) begin
          push_o.num    = 2'd1;
          push_o.ent[0] = '{x: held_q.x, y: held_q.y, last: 1'b0};
          kept_d        = held_q;
        end
        if (last_i) begin
          push_o.ent[push_o.num[0]] = '{x: pt_i.x, y: pt_i.y, last: 1'b1};
          push_o.num                = push_o.num + 2'd1;
          seen_d                    = SEEN_NONE;
        end else begin
          held_d = pt_i;
          seen_d = SEEN_MANY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
      kept_q <= '0;
      held_q <= '0;
    end else begin
      seen_q <= seen_d;
      kept_q <= kept_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/cvr_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cvr_result_fifo import cvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  push_t             push_i,
  output logic              room_o,
  cvr_kept_if.source        out_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;
  result_t            head;

  assign head          = mem_q[rd_q];
  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_x    = head.x;
  assign out_o.out_y    = head.y;
  assign out_o.out_last = head.last;

  assign pop    = out_o.valid & out_o.ready;
  assign room_o = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + FIFO_AW'(push_i.num);
    rd_d  = rd_q + FIFO_AW'(pop);
    cnt_d = cnt_q + FIFO_CW'(push_i.num) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.ent[0];
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + FIFO_AW'(1)] <= push_i.ent[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/collinear_vertex_remover_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                         Transaction
// in_i     in   point_x, point_y, is_last       one polyline vertex
// out_o    out  out_x, out_y, out_last          one kept vertex
//
// One vertex per cycle sustained while the result queue has room. A vertex is
// registered on accept, decided from the input register (one cross product
// against kept/held state), and its 0..2 results land in a 4-entry result
// queue, from whose head they show on out_o. The decision stage fires only
// with two free queue slots, so a stalled output backs up into in_i.ready.
// Asynchronous active-low reset empties the queue and starts a new polyline.

module collinear_vertex_remover_core import cvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cvr_vertex_if.sink  in_i,
  cvr_kept_if.source  out_o
);

  // input register
  logic   vld_q, vld_d;
  point_t pt_q;
  logic   last_q;

  logic   fire;
  logic   room;
  logic   in_acc;
  push_t  push;

  // free when empty or when the held vertex is decided this cycle
  assign in_i.ready = ~vld_q | fire;
  assign in_acc     = in_i.valid & in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (in_acc) begin
      vld_d = 1'b1;
    end else if (fire) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_q   <= '{x: in_i.point_x, y: in_i.point_y};
      last_q <= in_i.is_last;
    end
  end

  // decision stage: polyline state, cross-product test, result selection
  cvr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q),
    .pt_i   (pt_q),
    .last_i (last_q),
    .room_i (room),
    .fire_o (fire),
    .push_o (push)
  );

  // result queue decouples two-result vertices and output stalls
  cvr_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/collinear_vertex_remover_core_tb.sv
`timescale 1ns / 1ps

// Testbench for collinear_vertex_remover_core.
//
// Polylines are streamed into in_i one vertex per transaction. A behavioral
// predictor tracks the anchor (last kept) and pivot (held) vertices. For each
// accepted vertex it queues the kept vertices that vertex releases. Every
// out_o transaction is checked field by field against the oldest queued
// vertex.
//
// Sequence of tests:
//   directed shapes   single vertex, short lines, straight runs, spikes,
//                     repeated points, coordinate extremes
//   random polylines  three idle mixes on the two channels
//   output stall      long sink hold-off while the source keeps pushing

module collinear_vertex_remover_core_tb;
  import cvr_pkg::*;

  localparam int CLK_HALF    = 2;        // 4 ns period
  localparam int CYCLE_LIMIT = 400000;   // generous bound for a correct run
  localparam int DRAIN_GAP   = 20;       // pipeline is 2 stages plus a 4-deep queue

  logic clk_i;
  logic rst_ni;

  cvr_vertex_if vtx_ch ();
  cvr_kept_if   kept_ch ();

  collinear_vertex_remover_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (vtx_ch.sink),
    .out_o  (kept_ch.source)
  );

  // ---------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------
  result_t pending_kept[$];   // kept vertices predicted but not yet seen
  point_t  line_q[$];         // polyline being assembled for sending

  // predictor copy of the block state
  coord_t  anchor_x, anchor_y;  // last kept vertex
  coord_t  pivot_x, pivot_y;    // vertex waiting on its successor
  seen_e   seen;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;              // sink hold-off, counted down by the sink process

  int err_count;
  int n_sent;
  int n_lines;
  int n_checked;
  int cycle_count;
  result_t want;

  // ---------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d kept vertices outstanding",
               cycle_count, pending_kept.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sink side: random stalls, plus a counted hold-off when a test asks
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      kept_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      kept_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic void queue_kept(coord_t x, coord_t y, logic last);
    result_t r;
    r.x    = x;
    r.y    = y;
    r.last = last;
    pending_kept = {pending_kept, r};
  endfunction

  // Zero cross product of (anchor - pivot) x (next - pivot). Differences are
  // 25 bits, products 50 bits: longint holds them exactly.
  function automatic bit is_flat(coord_t nx, coord_t ny);
    longint apx, apy, npx, npy;
    apx = longint'(anchor_x) - longint'(pivot_x);
    apy = longint'(anchor_y) - longint'(pivot_y);
    npx = longint'(nx) - longint'(pivot_x);
    npy = longint'(ny) - longint'(pivot_y);
    return (npx * apy) == (npy * apx);
  endfunction

  task automatic predict_kept(coord_t x, coord_t y, logic last);
    bit judge;
    judge = 1'b0;
    case (seen)
      SEEN_NONE: begin
        // first vertex always goes out; a lone vertex closes the line at once
        queue_kept(x, y, last);
        if (!last) begin
          anchor_x = x;
          anchor_y = y;
          seen     = SEEN_ONE;
        end
      end
      SEEN_ONE: begin
        if (last) begin
          queue_kept(x, y, 1'b1);
          seen = SEEN_NONE;
        end else begin
          pivot_x = x;
          pivot_y = y;
          seen    = SEEN_TWO;
        end
      end
      SEEN_TWO: begin
        // three-vertex line: no test, all kept
        if (last) begin
          queue_kept(pivot_x, pivot_y, 1'b0);
          queue_kept(x, y, 1'b1);
          seen = SEEN_NONE;
        end else begin
          judge = 1'b1;
        end
      end
      default: judge = 1'b1;
    endcase

    if (judge) begin
      if (!is_flat(x, y)) begin
        queue_kept(pivot_x, pivot_y, 1'b0);
        anchor_x = pivot_x;
        anchor_y = pivot_y;
      end
      if (last) begin
        queue_kept(x, y, 1'b1);
        seen = SEEN_NONE;
      end else begin
        pivot_x = x;
        pivot_y = y;
        seen    = SEEN_MANY;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Output checker
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && kept_ch.valid && kept_ch.ready) begin
      if (pending_kept.size() == 0) begin
        $error("unexpected kept vertex (%0d, %0d) last=%0b",
               kept_ch.out_x, kept_ch.out_y, kept_ch.out_last);
        err_count++;
      end else begin
        want = pending_kept.pop_front();
        n_checked++;
        if (kept_ch.out_x !== want.x) begin
          $error("out_x mismatch: expected %0d, got %0d", want.x, kept_ch.out_x);
          err_count++;
        end
        if (kept_ch.out_y !== want.y) begin
          $error("out_y mismatch: expected %0d, got %0d", want.y, kept_ch.out_y);
          err_count++;
        end
        if (kept_ch.out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, got %0b",
                 want.last, kept_ch.out_last);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------
  // Drives one vertex at a falling edge and returns at the rising edge where
  // the transaction completes. valid stays high into the next call unless the
  // random idle gap drops it, so it is never lowered and raised in one step.
  task automatic send_vertex(coord_t x, coord_t y, logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      vtx_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    vtx_ch.valid   <= 1'b1;
    vtx_ch.point_x <= x;
    vtx_ch.point_y <= y;
    vtx_ch.is_last <= last;
    do @(posedge clk_i); while (!vtx_ch.ready);
    predict_kept(x, y, last);
    n_sent++;
    if (last) n_lines++;
  endtask

  task automatic add_point(int x, int y);
    point_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    line_q = {line_q, p};
  endtask

  task automatic send_line();
    foreach (line_q[i])
      send_vertex(line_q[i].x, line_q[i].y, i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Random polyline. Styles: full-range noise, a small grid where collinear
  // triples happen by chance, and walks along a heading with forward steps,
  // reversals, repeats and turns (small or large step sizes).
  task automatic send_random_line();
    int len, pick, style, k;
    int cx, cy, dx, dy;
    pick = $urandom_range(99);
    if (pick < 10)      len = $urandom_range(3, 1);
    else if (pick < 92) len = $urandom_range(10, 4);
    else                len = $urandom_range(24, 11);
    style = $urandom_range(3);
    if (style == 1 || style == 2) begin
      cx = $urandom_range(16) - 8;
      cy = $urandom_range(16) - 8;
    end else begin
      cx = $urandom;
      cy = $urandom;
    end
    if (style == 3) begin
      dx = $urandom_range(2000000) - 1000000;
      dy = $urandom_range(2000000) - 1000000;
    end else begin
      dx = $urandom_range(6) - 3;
      dy = $urandom_range(6) - 3;
    end
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (style == 0) begin
          cx = $urandom;
          cy = $urandom;
        end else if (style == 1) begin
          cx = $urandom_range(16) - 8;
          cy = $urandom_range(16) - 8;
        end else begin
          pick = $urandom_range(99);
          k    = $urandom_range(3, 1);
          if (pick < 60) begin
            cx += k * dx;
            cy += k * dy;
          end else if (pick < 75) begin
            // back along the heading: a spike
            cx -= k * dx;
            cy -= k * dy;
          end else if (pick < 85) begin
            // repeat the previous point
          end else begin
            dx = (style == 3) ? $urandom_range(2000000) - 1000000 : $urandom_range(6) - 3;
            dy = (style == 3) ? $urandom_range(2000000) - 1000000 : $urandom_range(6) - 3;
            cx += dx;
            cy += dy;
          end
        end
      end
      add_point(cx, cy);
    end
    send_line();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_shapes();
    src_idle_pct   = 28;
    sink_stall_pct = 74;
    // lone vertex
    add_point(5, -7);
    send_line();
    // two vertices
    add_point(0, 0);
    add_point(1, 1);
    send_line();
    // three collinear vertices pass unchanged
    add_point(0, 0);
    add_point(1, 1);
    add_point(2, 2);
    send_line();
    // straight run: both inner vertices drop
    add_point(0, 0);
    add_point(1, 1);
    add_point(2, 2);
    add_point(3, 3);
    send_line();
    // back-and-forth spike
    add_point(0, 0);
    add_point(10, 0);
    add_point(5, 0);
    add_point(10, 5);
    send_line();
    // repeated points
    add_point(3, 3);
    add_point(3, 3);
    add_point(3, 3);
    add_point(4, 9);
    send_line();
    // full-range diagonal then a corner: widest differences and products
    add_point(-8388608, -8388608);
    add_point(0, 0);
    add_point(8388607, 8388607);
    add_point(8388607, -8388608);
    send_line();
  endtask

  task automatic test_random_polylines(int src_pct, int sink_pct, int budget);
    int start;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start          = n_sent;
    while (n_sent - start < budget) send_random_line();
  endtask

  // Sink stops for a long stretch; the source keeps offering vertices, so
  // the result queue fills and in_i.ready must drop.
  task automatic test_output_stall();
    int start;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 300;
    start          = n_sent;
    while (n_sent - start < 60) send_random_line();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    vtx_ch.valid   = 1'b0;
    vtx_ch.point_x = '0;
    vtx_ch.point_y = '0;
    vtx_ch.is_last = 1'b0;
    kept_ch.ready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = 0;
    err_count      = 0;
    n_sent         = 0;
    n_lines        = 0;
    n_checked      = 0;
    cycle_count    = 0;
    anchor_x       = '0;
    anchor_y       = '0;
    pivot_x        = '0;
    pivot_y        = '0;
    seen           = SEEN_NONE;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_shapes();
    test_random_polylines(28, 74, 320);
    test_random_polylines(74, 28, 320);
    test_random_polylines(0, 0, 320);
    test_output_stall();

    @(negedge clk_i);
    vtx_ch.valid <= 1'b0;
    while (pending_kept.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);

    $display("Covered %0d polylines: %0d vertices in, %0d kept vertices checked,",
             n_lines, n_sent, n_checked);
    $display("under three idle mixes and a long output stall, in %0d cycles",
             cycle_count);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
design/cvr_pkg.sv
design/cvr_vertex_if.sv
design/cvr_kept_if.sv
design/cvr_cross_zero.sv
design/cvr_ctrl.sv
design/cvr_result_fifo.sv
design/collinear_vertex_remover_core.sv
tb/collinear_vertex_remover_core_tb.sv
